### hw/rtl/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// Shared types and constants for the sensor frame parser with dual checksum.
// ----------------------------------------------------------------------------
package sfp_pkg;

	localparam logic [7:0] HDR_FIRST  = 8'hAA;
	localparam logic [7:0] HDR_SECOND = 8'hFF;
	localparam logic [7:0] ID_FLOW    = 8'h51;
	localparam logic [7:0] ID_RANGE   = 8'h34;
	localparam logic [7:0] ID_ATT     = 8'h04;
	localparam logic [7:0] FLOW_MODE  = 8'h02;

	localparam logic [1:0] KIND_FLOW  = 2'd0;
	localparam logic [1:0] KIND_RANGE = 2'd1;
	localparam logic [1:0] KIND_ATT   = 2'd2;

	localparam int POS_W = 5;

	localparam logic [POS_W-1:0] LEN_FLOW  = 5'd21;
	localparam logic [POS_W-1:0] LEN_RANGE = 5'd13;
	localparam logic [POS_W-1:0] LEN_ATT   = 5'd15;

	localparam int TDATA_W = 120;

	typedef struct packed {
		logic [1:0]         frame_kind;
		logic               checksum_ok;
		logic [7:0]         status_code;
		logic signed [15:0] word_a;
		logic signed [15:0] word_b;
		logic signed [15:0] word_c;
		logic signed [15:0] word_d;
		logic [31:0]        distance_cm;
		logic [7:0]         quality;
	} res_t;

endpackage

### hw/rtl/sfp_parser.sv
// ----------------------------------------------------------------------------
// sfp_parser
// Frame state machine: header hunt, ID decode, field capture and the
// running sum / sum-of-sums checks. Emits one result at frame end.
// ----------------------------------------------------------------------------
module sfp_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [7:0]    in_byte,
	input  logic          res_stall,
	output logic          take,
	output logic          res_valid,
	output sfp_pkg::res_t res
);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_HEAD,
		PH_ID,
		PH_BODY
	} phase_t;

	phase_t                     phase_q;
	logic [sfp_pkg::POS_W-1:0]  pos_q;
	logic [1:0]                 kind_q;
	logic [7:0]                 sum_q;
	logic [7:0]                 sos_q;

	logic [7:0]                 status_q;
	logic signed [15:0]         wa_q;
	logic signed [15:0]         wb_q;
	logic signed [15:0]         wc_q;
	logic signed [15:0]         wd_q;
	logic [31:0]                dist_q;
	logic [7:0]                 qual_q;
	logic [7:0]                 chk_q;

	logic [sfp_pkg::POS_W-1:0]  len;
	logic [7:0]                 sum_n;
	logic [7:0]                 sos_n;
	logic                       last;
	logic                       add;
	logic                       bad_mode;
	logic                       id_known;
	logic [1:0]                 id_kind;

	always_comb begin
		case (kind_q)
			sfp_pkg::KIND_RANGE: len = sfp_pkg::LEN_RANGE;
			sfp_pkg::KIND_ATT:   len = sfp_pkg::LEN_ATT;
			default:             len = sfp_pkg::LEN_FLOW;
		endcase
	end

	always_comb begin
		id_known = 1'b1;
		case (in_byte)
			sfp_pkg::ID_FLOW:  id_kind = sfp_pkg::KIND_FLOW;
			sfp_pkg::ID_RANGE: id_kind = sfp_pkg::KIND_RANGE;
			sfp_pkg::ID_ATT:   id_kind = sfp_pkg::KIND_ATT;
			default: begin
				id_kind  = sfp_pkg::KIND_FLOW;
				id_known = 1'b0;
			end
		endcase
	end

	assign sum_n    = sum_q + in_byte;
	assign sos_n    = sos_q + sum_n;
	assign add      = pos_q < (len - 5'd2);
	assign bad_mode = (kind_q == sfp_pkg::KIND_FLOW) && (pos_q == 5'd4)
		&& (in_byte != sfp_pkg::FLOW_MODE);
	assign last     = (phase_q == PH_BODY) && (pos_q == (len - 5'd1));

	assign take      = in_valid && !(last && res_stall);
	assign res_valid = take && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			pos_q   <= '0;
			kind_q  <= sfp_pkg::KIND_FLOW;
			sum_q   <= '0;
			sos_q   <= '0;
		end else if (take) begin
			case (phase_q)
				PH_HUNT: begin
					if (in_byte == sfp_pkg::HDR_FIRST) begin
						pos_q   <= 5'd1;
						sum_q   <= in_byte;
						sos_q   <= in_byte;
						phase_q <= PH_HEAD;
					end
				end
				PH_HEAD: begin
					if (in_byte == sfp_pkg::HDR_SECOND) begin
						pos_q   <= pos_q + 5'd1;
						sum_q   <= sum_n;
						sos_q   <= sos_n;
						phase_q <= PH_ID;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
				PH_ID: begin
					if (id_known) begin
						kind_q  <= id_kind;
						pos_q   <= pos_q + 5'd1;
						sum_q   <= sum_n;
						sos_q   <= sos_n;
						phase_q <= PH_BODY;
					end else begin
						phase_q <= PH_HUNT;
					end
				end
				PH_BODY: begin
					if (bad_mode) begin
						phase_q <= PH_HUNT;
					end else begin
						pos_q <= pos_q + 5'd1;
						if (add) begin
							sum_q <= sum_n;
							sos_q <= sos_n;
						end
						if (last) begin
							phase_q <= PH_HUNT;
						end
					end
				end
				default: phase_q <= PH_HUNT;
			endcase
		end
	end

	// field capture by byte position
	always_ff @(posedge clk) begin
		if (take && phase_q == PH_BODY) begin
			if (pos_q == (len - 5'd2)) begin
				chk_q <= in_byte;
			end
			case (kind_q)
				sfp_pkg::KIND_RANGE: begin
					case (pos_q)
						5'd4:    status_q      <= in_byte;
						5'd5:    wa_q[7:0]     <= in_byte;
						5'd6:    wa_q[15:8]    <= in_byte;
						5'd7:    dist_q[7:0]   <= in_byte;
						5'd8:    dist_q[15:8]  <= in_byte;
						5'd9:    dist_q[23:16] <= in_byte;
						5'd10:   dist_q[31:24] <= in_byte;
						default: ;
					endcase
				end
				sfp_pkg::KIND_ATT: begin
					case (pos_q)
						5'd4:    wa_q[7:0]  <= in_byte;
						5'd5:    wa_q[15:8] <= in_byte;
						5'd6:    wb_q[7:0]  <= in_byte;
						5'd7:    wb_q[15:8] <= in_byte;
						5'd8:    wc_q[7:0]  <= in_byte;
						5'd9:    wc_q[15:8] <= in_byte;
						5'd10:   wd_q[7:0]  <= in_byte;
						5'd11:   wd_q[15:8] <= in_byte;
						5'd12:   status_q   <= in_byte;
						default: ;
					endcase
				end
				default: begin
					case (pos_q)
						5'd5:    status_q   <= in_byte;
						5'd6:    wa_q[7:0]  <= in_byte;
						5'd7:    wa_q[15:8] <= in_byte;
						5'd8:    wb_q[7:0]  <= in_byte;
						5'd9:    wb_q[15:8] <= in_byte;
						5'd10:   wc_q[7:0]  <= in_byte;
						5'd11:   wc_q[15:8] <= in_byte;
						5'd12:   wd_q[7:0]  <= in_byte;
						5'd13:   wd_q[15:8] <= in_byte;
						5'd18:   qual_q     <= in_byte;
						default: ;
					endcase
				end
			endcase
		end
	end

	// last byte is the sum-of-sums check, compared as it arrives
	always_comb begin
		res             = '0;
		res.frame_kind  = kind_q;
		res.checksum_ok = (sum_q == chk_q) && (sos_q == in_byte);
		case (kind_q)
			sfp_pkg::KIND_RANGE: begin
				res.status_code = status_q;
				res.word_a      = wa_q;
				res.distance_cm = dist_q;
			end
			sfp_pkg::KIND_ATT: begin
				res.status_code = status_q;
				res.word_a      = wa_q;
				res.word_b      = wb_q;
				res.word_c      = wc_q;
				res.word_d      = wd_q;
			end
			default: begin
				res.status_code = status_q;
				res.word_a      = wa_q;
				res.word_b      = -wb_q;
				res.word_c      = wc_q;
				res.word_d      = -wd_q;
				res.quality     = qual_q;
			end
		endcase
	end

endmodule

### hw/rtl/sfp_out_buf.sv
// ----------------------------------------------------------------------------
// sfp_out_buf
// Result register towards the master side; holds an item until taken.
// ----------------------------------------------------------------------------
module sfp_out_buf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  sfp_pkg::res_t res_in,
	input  logic          ready,
	output logic          valid,
	output logic          stall,
	output sfp_pkg::res_t res_out
);

	logic          valid_q;
	sfp_pkg::res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

	assign valid   = valid_q;
	assign stall   = valid_q && !ready;
	assign res_out = res_q;

endmodule

### hw/rtl/sensor_frame_parser_dual_checksum.sv
// ----------------------------------------------------------------------------
// sensor_frame_parser_dual_checksum
// Serial sensor frame parser with sum and sum-of-sums checks.
// ----------------------------------------------------------------------------
// Slave side takes one received byte per item. The parser hunts for the
// header AA FF, decodes the ID (optical flow, range, attitude) and captures
// the little-endian fields of the fixed-length frame as the bytes pass.
// Master side gives one item per complete frame, with the kind in tuser and
// the decoded fields plus the check flag in tdata; frames with a bad flow
// mode or an unknown ID give nothing.
// Throughput: one byte per cycle, set by the input register feeding the
// parser state, unless a frame's last byte waits on a held result.
// The last frame byte passes the input register, then the result register
// loads the result, which is then valid on the master side.
// Reset clears the parser to header hunt and empties both registers.
// If the receiver stalls, bytes keep flowing until the last byte of the next
// frame reaches the parser while the previous result is still held; tready
// then drops until the result is taken.
// ----------------------------------------------------------------------------
module sensor_frame_parser_dual_checksum (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,  // [7:0] rx_byte
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [0] checksum_ok, [8:1] status_code, [24:9] word_a, [40:25] word_b,
	// [56:41] word_c, [72:57] word_d, [104:73] distance_cm, [112:105] quality
	output logic [sfp_pkg::TDATA_W-1:0] m_tdata,
	output logic [1:0]                   m_tuser   // [1:0] frame_kind
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          take;
	logic          res_valid;
	logic          stall;
	sfp_pkg::res_t res;
	sfp_pkg::res_t res_out;

	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	sfp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s1),
		.in_byte   (byte_s1),
		.res_stall (stall),
		.take      (take),
		.res_valid (res_valid),
		.res       (res)
	);

	sfp_out_buf u_out_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (res_valid),
		.res_in  (res),
		.ready   (m_tready),
		.valid   (m_tvalid),
		.stall   (stall),
		.res_out (res_out)
	);

	assign m_tuser = res_out.frame_kind;
	assign m_tdata = {7'd0, res_out.quality, res_out.distance_cm,
		res_out.word_d, res_out.word_c, res_out.word_b, res_out.word_a,
		res_out.status_code, res_out.checksum_ok};

endmodule

### tb/sensor_frame_parser_dual_checksum_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_parser_dual_checksum_tb
// Self-checking bench for the serial sensor frame parser.
// ----------------------------------------------------------------------------
// Builds flow, range and attitude frames with their two check bytes, mixed
// with noise, broken headers, unknown IDs, bad flow modes, bad checks and cut
// frames. Every accepted byte goes through a local frame parser that queues
// the decoded frame it completes; each result item is compared field by field
// with the oldest queued frame. Both sides idle at random and the receiver
// holds off once for long enough to back the block up.
// ----------------------------------------------------------------------------
module sensor_frame_parser_dual_checksum_tb;

	localparam int IDLE_LIMIT = 4000;
	localparam int LONG_HOLD  = 400;

	typedef enum logic [1:0] {ST_SEEK, ST_SYNC2, ST_IDENT, ST_PAYLOAD} parse_st_t;
	typedef enum int {CK_GOOD, CK_SUM, CK_SOS, CK_BOTH} ck_fault_t;

	typedef struct {
		logic [1:0]         kind;
		logic               ok;
		logic [7:0]         status;
		logic signed [15:0] wa;
		logic signed [15:0] wb;
		logic signed [15:0] wc;
		logic signed [15:0] wd;
		logic [31:0]        range_cm;
		logic [7:0]         qual;
	} frame_res_t;

	logic                         clk      = 1'b0;
	logic                         arst_n   = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [7:0]                   s_tdata  = '0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [sfp_pkg::TDATA_W-1:0] m_tdata;
	logic [1:0]                   m_tuser;

	logic [7:0]  rx_bytes_q [$];
	frame_res_t  decoded_q [$];
	logic [7:0]  build_buf [0:20];

	// local parser state
	parse_st_t   pst;
	logic [4:0]  ppos;
	logic [1:0]  pkind;
	logic [7:0]  psum;
	logic [7:0]  psos;
	logic [7:0]  seen_buf [0:20];

	int  tx_gap;
	int  tx_free;
	int  rx_hold;
	int  rx_free;
	bit  hold_done;
	int  frames_out;
	int  stall_cycles;
	bit  failed;

	sensor_frame_parser_dual_checksum dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	function automatic int frame_size(input logic [1:0] k);
		if (k == sfp_pkg::KIND_RANGE)
			return int'(sfp_pkg::LEN_RANGE);
		if (k == sfp_pkg::KIND_ATT)
			return int'(sfp_pkg::LEN_ATT);
		return int'(sfp_pkg::LEN_FLOW);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] seen_le16(input int p);
		return {seen_buf[p + 1], seen_buf[p]};
	endfunction

	task automatic keep_byte(input logic [7:0] b, input bit add);
		seen_buf[ppos] = b;
		ppos = ppos + 5'd1;
		if (add) begin
			psum = psum + b;
			psos = psos + psum;
		end
	endtask

	task automatic parse_byte(input logic [7:0] b);
		int n;
		frame_res_t r;
		case (pst)
			ST_SEEK: begin
				if (b == sfp_pkg::HDR_FIRST) begin
					ppos = '0;
					psum = '0;
					psos = '0;
					keep_byte(b, 1'b1);
					pst = ST_SYNC2;
				end
			end
			ST_SYNC2: begin
				if (b == sfp_pkg::HDR_SECOND) begin
					keep_byte(b, 1'b1);
					pst = ST_IDENT;
				end else begin
					pst = ST_SEEK;
				end
			end
			ST_IDENT: begin
				if (b == sfp_pkg::ID_FLOW || b == sfp_pkg::ID_RANGE
						|| b == sfp_pkg::ID_ATT) begin
					pkind = (b == sfp_pkg::ID_FLOW) ? sfp_pkg::KIND_FLOW
						: (b == sfp_pkg::ID_RANGE) ? sfp_pkg::KIND_RANGE
						: sfp_pkg::KIND_ATT;
					keep_byte(b, 1'b1);
					pst = ST_PAYLOAD;
				end else begin
					pst = ST_SEEK;
				end
			end
			default: begin
				n = frame_size(pkind);
				if (pkind == sfp_pkg::KIND_FLOW && ppos == 5'd4
						&& b != sfp_pkg::FLOW_MODE) begin
					pst = ST_SEEK;
				end else begin
					keep_byte(b, int'(ppos) < n - 2);
					if (int'(ppos) >= n) begin
						pst = ST_SEEK;
						r = '{default: '0};
						r.kind = pkind;
						r.ok = (psum == seen_buf[n - 2]) && (psos == seen_buf[n - 1]);
						if (pkind == sfp_pkg::KIND_RANGE) begin
							r.status = seen_buf[4];
							r.wa = seen_le16(5);
							r.range_cm = {seen_buf[10], seen_buf[9], seen_buf[8],
								seen_buf[7]};
						end else if (pkind == sfp_pkg::KIND_ATT) begin
							r.status = seen_buf[12];
							r.wa = seen_le16(4);
							r.wb = seen_le16(6);
							r.wc = seen_le16(8);
							r.wd = seen_le16(10);
						end else begin
							r.status = seen_buf[5];
							r.wa = seen_le16(6);
							r.wb = -seen_le16(8);
							r.wc = seen_le16(10);
							r.wd = -seen_le16(12);
							r.qual = seen_buf[18];
						end
						decoded_q.push_back(r);
					end
				end
			end
		endcase
	endtask

	function automatic void cmp_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
			failed = 1'b1;
		end
	endfunction

	task automatic check_frame();
		frame_res_t e;
		frame_res_t g;
		g.kind     = m_tuser;
		g.ok       = m_tdata[0];
		g.status   = m_tdata[8:1];
		g.wa       = m_tdata[24:9];
		g.wb       = m_tdata[40:25];
		g.wc       = m_tdata[56:41];
		g.wd       = m_tdata[72:57];
		g.range_cm = m_tdata[104:73];
		g.qual     = m_tdata[112:105];
		if (decoded_q.size() == 0) begin
			$display("%0t: unexpected result, expected none, got kind %0d tdata %0h",
				$time, g.kind, m_tdata);
			failed = 1'b1;
		end else begin
			e = decoded_q.pop_front();
			cmp_field("frame_kind", e.kind, g.kind);
			cmp_field("checksum_ok", e.ok, g.ok);
			cmp_field("status_code", e.status, g.status);
			cmp_field("word_a", e.wa, g.wa);
			cmp_field("word_b", e.wb, g.wb);
			cmp_field("word_c", e.wc, g.wc);
			cmp_field("word_d", e.wd, g.wd);
			cmp_field("distance_cm", e.range_cm, g.range_cm);
			cmp_field("quality", e.qual, g.qual);
		end
	endtask

	// stimulus builders
	task automatic new_frame(input logic [1:0] k);
		int i;
		for (i = 0; i < 21; i++)
			build_buf[i] = 8'($urandom);
		build_buf[0] = sfp_pkg::HDR_FIRST;
		build_buf[1] = sfp_pkg::HDR_SECOND;
		build_buf[2] = (k == sfp_pkg::KIND_RANGE) ? sfp_pkg::ID_RANGE
			: (k == sfp_pkg::KIND_ATT) ? sfp_pkg::ID_ATT : sfp_pkg::ID_FLOW;
		if (k == sfp_pkg::KIND_FLOW)
			build_buf[4] = sfp_pkg::FLOW_MODE;
	endtask

	task automatic set_le16(input int p, input logic [15:0] v);
		build_buf[p]     = v[7:0];
		build_buf[p + 1] = v[15:8];
	endtask

	task automatic send_frame(input logic [1:0] k, input ck_fault_t fault, input int keep);
		int n;
		int i;
		logic [7:0] s;
		logic [7:0] ss;
		n = frame_size(k);
		s = '0;
		ss = '0;
		for (i = 0; i < n - 2; i++) begin
			s = s + build_buf[i];
			ss = ss + s;
		end
		if (fault == CK_SUM || fault == CK_BOTH)
			s = s ^ 8'($urandom_range(1, 255));
		if (fault == CK_SOS || fault == CK_BOTH)
			ss = ss ^ 8'($urandom_range(1, 255));
		build_buf[n - 2] = s;
		build_buf[n - 1] = ss;
		for (i = 0; i < n && i < keep; i++)
			rx_bytes_q.push_back(build_buf[i]);
	endtask

	task automatic send_random_frame();
		logic [1:0] k;
		int r;
		ck_fault_t f;
		k = 2'($urandom_range(0, 2));
		r = $urandom_range(0, 99);
		f = (r < 75) ? CK_GOOD : (r < 83) ? CK_SUM : (r < 91) ? CK_SOS : CK_BOTH;
		new_frame(k);
		send_frame(k, f, 21);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			tx_gap <= 0;
			tx_free <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (tx_gap > 0 || rx_bytes_q.size() == 0) begin
				s_tvalid <= 1'b0;
				if (tx_gap > 0)
					tx_gap <= tx_gap - 1;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata <= rx_bytes_q.pop_front();
				if (tx_free > 0) begin
					tx_free <= tx_free - 1;
				end else if ($urandom_range(0, 39) == 0) begin
					tx_free <= $urandom_range(20, 80);
				end else begin
					tx_gap <= pick_gap();
				end
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_hold <= 0;
			rx_free <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && frames_out >= 12) begin
			m_tready <= 1'b0;
			rx_hold <= LONG_HOLD;
			hold_done <= 1'b1;
		end else if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else if (rx_free > 0) begin
			m_tready <= 1'b1;
			rx_free <= rx_free - 1;
		end else if ($urandom_range(0, 39) == 0) begin
			m_tready <= 1'b1;
			rx_free <= $urandom_range(20, 80);
		end else begin
			int g;
			g = pick_gap();
			m_tready <= (g == 0);
			rx_hold <= (g > 0) ? g - 1 : 0;
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				parse_byte(s_tdata);
			if (m_tvalid && m_tready) begin
				check_frame();
				frames_out <= frames_out + 1;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= IDLE_LIMIT) begin
				$display("timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		int i;
		int r;
		int n;
		logic [7:0] b;
		pst = ST_SEEK;
		ppos = '0;
		pkind = sfp_pkg::KIND_FLOW;
		psum = '0;
		psos = '0;
		frames_out = 0;
		stall_cycles = 0;
		failed = 1'b0;

		// flow frame at the field extremes
		new_frame(sfp_pkg::KIND_FLOW);
		build_buf[5] = 8'h00;
		set_le16(6, 16'h8000);
		set_le16(8, 16'h8000);
		set_le16(10, 16'h7FFF);
		set_le16(12, 16'h0000);
		build_buf[18] = 8'hFF;
		send_frame(sfp_pkg::KIND_FLOW, CK_GOOD, 21);
		// range, full distance and most negative angle
		new_frame(sfp_pkg::KIND_RANGE);
		build_buf[4] = 8'hFF;
		set_le16(5, 16'h8000);
		set_le16(7, 16'hFFFF);
		set_le16(9, 16'hFFFF);
		send_frame(sfp_pkg::KIND_RANGE, CK_GOOD, 21);
		// range, empty payload
		new_frame(sfp_pkg::KIND_RANGE);
		for (i = 3; i <= 10; i++)
			build_buf[i] = 8'h00;
		send_frame(sfp_pkg::KIND_RANGE, CK_GOOD, 21);
		// attitude
		new_frame(sfp_pkg::KIND_ATT);
		set_le16(4, 16'h7FFF);
		set_le16(6, 16'h8000);
		set_le16(8, 16'hFFFF);
		set_le16(10, 16'h0001);
		build_buf[12] = 8'hFF;
		send_frame(sfp_pkg::KIND_ATT, CK_GOOD, 21);
		// second header byte wrong, and not taken as a fresh first byte
		rx_bytes_q.push_back(sfp_pkg::HDR_FIRST);
		rx_bytes_q.push_back(sfp_pkg::HDR_FIRST);
		rx_bytes_q.push_back(sfp_pkg::HDR_SECOND);
		rx_bytes_q.push_back(sfp_pkg::ID_RANGE);
		new_frame(sfp_pkg::KIND_ATT);
		send_frame(sfp_pkg::KIND_ATT, CK_GOOD, 21);
		// unknown ID
		rx_bytes_q.push_back(sfp_pkg::HDR_FIRST);
		rx_bytes_q.push_back(sfp_pkg::HDR_SECOND);
		rx_bytes_q.push_back(8'h99);
		// flow frame with wrong mode is dropped at the mode byte
		new_frame(sfp_pkg::KIND_FLOW);
		build_buf[4] = 8'h03;
		send_frame(sfp_pkg::KIND_FLOW, CK_GOOD, 21);
		// check byte faults
		new_frame(sfp_pkg::KIND_FLOW);
		send_frame(sfp_pkg::KIND_FLOW, CK_SUM, 21);
		new_frame(sfp_pkg::KIND_RANGE);
		send_frame(sfp_pkg::KIND_RANGE, CK_SOS, 21);
		new_frame(sfp_pkg::KIND_ATT);
		send_frame(sfp_pkg::KIND_ATT, CK_BOTH, 21);
		// header pattern inside a frame is plain data
		new_frame(sfp_pkg::KIND_FLOW);
		build_buf[6] = sfp_pkg::HDR_FIRST;
		build_buf[7] = sfp_pkg::HDR_SECOND;
		send_frame(sfp_pkg::KIND_FLOW, CK_GOOD, 21);

		// random part: mostly whole frames, some damage and noise
		while (rx_bytes_q.size() < 500) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				send_random_frame();
			end else if (r < 78) begin
				new_frame(sfp_pkg::KIND_FLOW);
				do b = 8'($urandom); while (b == sfp_pkg::FLOW_MODE);
				build_buf[4] = b;
				send_frame(sfp_pkg::KIND_FLOW, CK_GOOD, 21);
			end else if (r < 84) begin
				n = $urandom_range(0, 2);
				new_frame(2'(n));
				send_frame(2'(n), CK_GOOD, $urandom_range(3, frame_size(2'(n)) - 1));
			end else if (r < 90) begin
				rx_bytes_q.push_back(sfp_pkg::HDR_FIRST);
				do b = 8'($urandom); while (b == sfp_pkg::HDR_SECOND);
				rx_bytes_q.push_back(b);
			end else if (r < 95) begin
				rx_bytes_q.push_back(sfp_pkg::HDR_FIRST);
				rx_bytes_q.push_back(sfp_pkg::HDR_SECOND);
				do b = 8'($urandom);
				while (b == sfp_pkg::ID_FLOW || b == sfp_pkg::ID_RANGE
					|| b == sfp_pkg::ID_ATT);
				rx_bytes_q.push_back(b);
			end else begin
				n = $urandom_range(1, 6);
				for (i = 0; i < n; i++)
					rx_bytes_q.push_back(8'($urandom));
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (rx_bytes_q.size() != 0 || s_tvalid || decoded_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (failed || decoded_q.size() != 0) begin
			$display("RESULT: ERROR");
		end else begin
			$display("RESULT: OK");
		end
		$finish;
	end

endmodule

### sensor_frame_parser_dual_checksum.f
hw/rtl/sfp_pkg.sv
hw/rtl/sfp_parser.sv
hw/rtl/sfp_out_buf.sv
hw/rtl/sensor_frame_parser_dual_checksum.sv
tb/sensor_frame_parser_dual_checksum_tb.sv
